// ===== rtl/core/bci_pkg.sv =====
// Shared types and constants of the interpolating bit crusher.
`timescale 1ns / 1ps

package bci_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 15;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam int FRAC_W     = 15;
   localparam int PROD_W     = 32;

   // Phase wraps here; a capture happens on every wrap
   localparam logic [RATE_W:0] PHASE_WRAP = 16'd32767;

   localparam logic [RATE_W-1:0]  RATE_STEP_RESET  = 15'h7FFF;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET      = 4'd0;
   // Loudness compensation thresholds on the crush shift
   localparam logic [SHIFT_W-1:0] LOUD_STEP_A      = 4'd12;
   localparam logic [SHIFT_W-1:0] LOUD_STEP_B      = 4'd13;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RATE_STEP   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRUSH_SHIFT = 8'd1;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One classified item: the held pair and the phase to interpolate at
   typedef struct packed {
      sample_type        last;
      sample_type        next;
      logic [RATE_W-1:0] phase;
   } bci_job_type;

endpackage

// ===== rtl/core/bci_if.sv =====
// Handshake interfaces: sample input, sample output and register writes.
`timescale 1ns / 1ps

interface bci_in_if;
   import bci_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bci_out_if;
   import bci_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface bci_csr_if;
   import bci_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/bci_front.sv =====
// Front end: registers, phase accumulator, crush and held-sample update.
`timescale 1ns / 1ps

module bci_front (
   input  logic                 clock,
   input  logic                 reset,
   bci_in_if.sink               req_if,
   bci_csr_if.sink              csr_if,
   output logic                 push_valid,
   input  logic                 push_ready,
   output bci_pkg::bci_job_type push_job
);
   import bci_pkg::*;

   logic [RATE_W-1:0]  rate_ff,  rate_in;
   logic [SHIFT_W-1:0] shift_ff, shift_in;
   logic [RATE_W-1:0]  phase_ff, phase_in;
   sample_type         last_ff,  last_in;
   sample_type         next_ff,  next_in;

   logic [RATE_W:0]    phase_sum;
   logic               wrap;
   logic [SHIFT_W-1:0] up_shift;
   sample_type         shifted;
   sample_type         crushed;
   logic               accept;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid & push_ready;

   always_comb begin
      rate_in  = rate_ff;
      shift_in = shift_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_RATE_STEP:   rate_in  = csr_if.wdata[RATE_W-1:0];
            REG_CRUSH_SHIFT: shift_in = csr_if.wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   // floor shift right, then back up by the same amount, or slightly less above 12
   assign up_shift = shift_ff - SHIFT_W'(shift_ff > LOUD_STEP_A)
                              - SHIFT_W'(shift_ff > LOUD_STEP_B);
   assign shifted  = req_if.sample_in >>> shift_ff;
   assign crushed  = shifted <<< up_shift;

   assign phase_sum = {1'b0, phase_ff} + {1'b0, rate_ff};
   assign wrap      = (phase_sum >= PHASE_WRAP);

   always_comb begin
      phase_in = phase_ff;
      last_in  = last_ff;
      next_in  = next_ff;
      if (accept) begin
         phase_in = wrap ? RATE_W'(phase_sum - PHASE_WRAP) : phase_sum[RATE_W-1:0];
         if (wrap) begin
            last_in = next_ff;
            next_in = crushed;
         end
      end
   end

   always_comb begin
      push_job.phase = wrap ? RATE_W'(phase_sum - PHASE_WRAP) : phase_sum[RATE_W-1:0];
      push_job.last  = wrap ? next_ff : last_ff;
      push_job.next  = wrap ? crushed : next_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_STEP_RESET;
         shift_ff <= SHIFT_RESET;
         phase_ff <= '0;
         last_ff  <= '0;
         next_ff  <= '0;
      end else begin
         rate_ff  <= rate_in;
         shift_ff <= shift_in;
         phase_ff <= phase_in;
         last_ff  <= last_in;
         next_ff  <= next_in;
      end
   end

endmodule

// ===== rtl/core/bci_queue.sv =====
// Short FIFO of classified items between front and back.
`timescale 1ns / 1ps

module bci_queue #(
   parameter int DEPTH = bci_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  bci_pkg::bci_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output bci_pkg::bci_job_type pop_job
);
   import bci_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bci_job_type       entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_job    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/bci_back.sv =====
// Back end: interpolation multiply, then saturating add into the output register.
`timescale 1ns / 1ps

module bci_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  bci_pkg::bci_job_type pop_job,
   bci_out_if.source            rsp_if
);
   import bci_pkg::*;

   // Stage 1: product of difference and phase
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [PROD_W-1:0]  s1_prod_ff,  s1_prod_in;
   sample_type                s1_last_ff;
   // Stage 2: output register
   logic                      s2_valid_ff, s2_valid_in;
   sample_type                s2_sample_ff, s2_sample_in;

   logic signed [SAMPLE_W:0]    diff;
   logic signed [PROD_W:0]      prod_full;
   logic signed [PROD_W-1:0]    prod_shr;
   logic signed [SAMPLE_W:0]    part;
   logic signed [SAMPLE_W+1:0]  total;
   logic                        s2_load, s1_load;

   assign s2_load   = !s2_valid_ff || rsp_if.ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign pop_ready = s1_load;

   // 17-bit exact difference times unsigned phase
   assign diff      = {pop_job.next[SAMPLE_W-1], pop_job.next}
                    - {pop_job.last[SAMPLE_W-1], pop_job.last};
   assign prod_full = diff * $signed({1'b0, pop_job.phase});
   assign s1_prod_in = prod_full[PROD_W-1:0];

   // floor divide by 2^15, then saturating add
   assign prod_shr = s1_prod_ff >>> FRAC_W;
   assign part     = prod_shr[SAMPLE_W:0];
   assign total    = {{2{s1_last_ff[SAMPLE_W-1]}}, s1_last_ff} + {part[SAMPLE_W], part};

   always_comb begin
      if (total[SAMPLE_W+1:SAMPLE_W-1] == 3'b000 || total[SAMPLE_W+1:SAMPLE_W-1] == 3'b111) begin
         s2_sample_in = total[SAMPLE_W-1:0];
      end else if (total[SAMPLE_W+1]) begin
         s2_sample_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         s2_sample_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (s1_load) begin
         s1_valid_in = pop_valid;
      end
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && pop_valid) begin
         s1_prod_ff <= s1_prod_in;
         s1_last_ff <= pop_job.last;
      end
      if (s2_load && s1_valid_ff) begin
         s2_sample_ff <= s2_sample_in;
      end
   end

   assign rsp_if.valid      = s2_valid_ff;
   assign rsp_if.sample_out = s2_sample_ff;

endmodule

// ===== rtl/core/bit_crusher_interpolated.sv =====
// Top level of the interpolating bit crusher.
`timescale 1ns / 1ps

// Bit crusher with sample-rate reduction and linear interpolation. Each signed
// Q15 sample item in gives one sample item out. A phase accumulator adds
// rate_step (register 0, reset 32767) per item and wraps at 32767; on a wrap the
// held "next" sample moves to "last" and the input, with crush_shift (register
// 1, reset 0) low bits dropped, becomes the new "next". The output is
// last + floor((next - last) * phase / 32768), saturated to 16 bits. Rate: one
// item per clock while the output is taken; the phase and held-sample update
// is a registered loop in the front end, and the back end spends one stage on
// the single 17x16 multiply and one on the saturating add. After the input
// accept, a result passes the queue write, then the multiply stage, then the
// output register before output valid rises.
// A queue (two entries by default) separates front and back, and the output
// register lets a new item in while a result waits. Register writes are always
// taken (csr ready tied high) and should be made while no item is in flight;
// unknown register indexes are ignored.

module bit_crusher_interpolated #(
   parameter int QUEUE_DEPTH = bci_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
   input  logic       clock,
   input  logic       reset,
   bci_in_if.sink     req_if,
   bci_out_if.source  rsp_if,
   bci_csr_if.sink    csr_if
);
   import bci_pkg::*;

   // front -> queue
   logic        q_push_valid;
   logic        q_push_ready;
   bci_job_type q_push_job;
   // queue -> back
   logic        q_pop_valid;
   logic        q_pop_ready;
   bci_job_type q_pop_job;

   // accept, crush, update the held pair
   bci_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job)
   );

   bci_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_job   (q_push_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_job    (q_pop_job)
   );

   // interpolate and saturate
   bci_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_pop_valid),
      .pop_ready (q_pop_ready),
      .pop_job   (q_pop_job),
      .rsp_if    (rsp_if)
   );

`ifndef SYNTHESIS
   // reset leaves nothing queued and no result pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!q_pop_valid && !rsp_if.valid))
      else $error("items survive reset");

   // phase handed to the back end is always below the wrap point
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      q_push_valid |-> (q_push_job.phase != {RATE_W{1'b1}}))
      else $error("phase at or beyond wrap");

   // the queue only fills from an accepted input item
   a_queue_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(q_pop_valid) && !$past(reset)) |-> $past(req_if.valid && req_if.ready))
      else $error("queue filled without an accepted item");
`endif

endmodule

// ===== tb/sv/bci_checker.sv =====
// Checker for the interpolating bit crusher: predicts every output sample and compares.
`timescale 1ns / 1ps

module bci_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  bci_pkg::sample_type            req_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  bci_pkg::sample_type            rsp_sample,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bci_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bci_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   import bci_pkg::*;

   localparam int REPORT_MAX = 10;

   // predictor copy of the registers and held state
   logic [RATE_W-1:0]  rate_step_q;
   logic [SHIFT_W-1:0] crush_shift_q;
   logic [RATE_W:0]    phase_q;
   sample_type         last_q;
   sample_type         next_q;

   sample_type expected_samples[$];
   int         mismatches = 0;

   // floor-divide by 2^sh, then scale back up with loudness compensation
   function automatic int crush_sample(sample_type s_in, logic [SHIFT_W-1:0] sh);
      int q;
      int up;
      q  = int'(s_in) >>> sh;
      up = int'(sh);
      if (sh > LOUD_STEP_A) up--;
      if (sh > LOUD_STEP_B) up--;
      return q * (1 << up);
   endfunction

   // advance phase, capture on wrap, interpolate between held samples
   function automatic sample_type crush_interp_step(sample_type s_in);
      logic [RATE_W+1:0] acc;
      int                diff;
      longint            prod;
      longint            y;
      acc = {1'b0, phase_q} + {2'b00, rate_step_q};
      if (acc >= {1'b0, PHASE_WRAP}) begin
         acc    = acc - {1'b0, PHASE_WRAP};
         last_q = next_q;
         next_q = sample_type'(crush_sample(s_in, crush_shift_q));
      end
      phase_q = acc[RATE_W:0];
      diff = int'(next_q) - int'(last_q);
      prod = longint'(diff) * longint'(phase_q);
      y    = longint'(last_q) + (prod >>> FRAC_W);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      return sample_type'(y);
   endfunction

   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rate_step_q   = RATE_STEP_RESET;
         crush_shift_q = SHIFT_RESET;
         phase_q       = '0;
         last_q        = '0;
         next_q        = '0;
         expected_samples.delete();
      end else begin
         // results first: one edge may carry an old result and a new item
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("[%0t] output item with none expected: sample_out %0d",
                           $realtime, rsp_sample);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("[%0t] sample_out mismatch: expected %0d, got %0d",
                              $realtime, want, rsp_sample);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RATE_STEP:   rate_step_q   = csr_wdata[RATE_W-1:0];
               REG_CRUSH_SHIFT: crush_shift_q = csr_wdata[SHIFT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_samples.push_back(crush_interp_step(req_sample));
      end
      fail_count  <= mismatches;
      outstanding <= expected_samples.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: clock, reset, stimulus and verdict for the interpolating bit crusher.
`timescale 1ns / 1ps

module testbench;
   import bci_pkg::*;

   localparam int MAX_CYCLES    = 400000;  // generous: ~2000 items
   localparam int DRAIN_CYCLES  = 8;       // pipeline: queue, multiply stage, output register; spare margin
   localparam int RANDOM_PHASES = 20;
   localparam int PHASE_ITEMS   = 100;

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   fail_count;
   int   outstanding;
   int   req_run_left = 0;
   int   rsp_run_left = 0;

   bci_in_if  req_if ();
   bci_out_if rsp_if ();
   bci_csr_if csr_if ();

   bit_crusher_interpolated i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   bci_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_sample  (req_if.sample_in),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_sample  (rsp_if.sample_out),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_index   (csr_if.index),
      .csr_wdata   (csr_if.wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case a handshake never completes
   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles, %0d items still expected", cycles, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Idle gap before an item: random, with occasional stretches of zero gaps
   // so that back-to-back traffic also gets exercised.
   function automatic int draw_gap(ref int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(20, 100);
         return 0;
      end
      return $urandom_range(0, 16);
   endfunction

   // full-range samples, weighted toward the rails and around zero
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return sample_type'($urandom_range(0, 1) ? 0 : -1);
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Output side: ready drops for a random number of cycles before each item.
   initial begin : rsp_stall
      int gap;
      rsp_if.ready <= 1'b0;
      forever begin
         gap = draw_gap(rsp_run_left);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   // One input item; valid stays high afterwards so zero-gap items go back to back.
   task automatic send_sample(input sample_type s);
      int gap;
      gap = draw_gap(req_run_left);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.sample_in <= s;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   // Stop the input and wait until every expected item has come out.
   // The first edge lets the checker count the item accepted at this one.
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register writes only with the pipeline empty.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      hold_until_drained();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      csr_if.valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] wdata;
      int                    hold_at;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.sample_in <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.index     <= '0;
      csr_if.wdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed ---
      // reset settings: every input captured, no crushing
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sd1);
      send_sample(16'sd0);

      // deepest crush; loudness compensation kicks in above 12 and 13
      write_reg(REG_CRUSH_SHIFT, 16'd15);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(-16'sd1);
      write_reg(REG_CRUSH_SHIFT, 16'd14);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      write_reg(REG_CRUSH_SHIFT, 16'd13);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      // half rate, rail-to-rail: widest interpolation swing
      write_reg(REG_CRUSH_SHIFT, 16'd0);
      write_reg(REG_RATE_STEP, 16'd16384);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      // zero rate: phase frozen, held samples never change
      write_reg(REG_RATE_STEP, 16'd0);
      send_sample(16'sd12345);
      send_sample(-16'sd5);

      // slowest nonzero rate at the shift threshold
      write_reg(REG_RATE_STEP, 16'd1);
      write_reg(REG_CRUSH_SHIFT, 16'd12);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      // bits above each register width are dropped; unknown indexes do nothing
      write_reg(REG_RATE_STEP, 16'hFFFF);
      write_reg(REG_CRUSH_SHIFT, 16'hFFF0);
      write_reg(8'd2, 16'h0001);
      write_reg(8'hFF, 16'hFFFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      // --- random phases ---
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wdata = 16'($urandom);
         case ($urandom_range(0, 7))
            0:       wdata[RATE_W-1:0] = 15'd0;
            1:       wdata[RATE_W-1:0] = 15'd1;
            2:       wdata[RATE_W-1:0] = 15'd32767;
            3:       wdata[RATE_W-1:0] = 15'd32766;
            4:       wdata[RATE_W-1:0] = 15'd16384;
            default: wdata[RATE_W-1:0] = 15'($urandom_range(0, 32767));
         endcase
         write_reg(REG_RATE_STEP, wdata);

         wdata = 16'($urandom);
         if (p == 0)
            wdata[SHIFT_W-1:0] = 4'd0;
         else if (p == 1)
            wdata[SHIFT_W-1:0] = 4'd15;
         write_reg(REG_CRUSH_SHIFT, wdata);

         if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(2, 255)), 16'($urandom));

         // every third phase the sender stops once until the output side catches up
         hold_at = (p % 3 == 0) ? $urandom_range(10, PHASE_ITEMS - 10) : -1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == hold_at)
               hold_until_drained();
            send_sample(rand_sample());
         end
      end

      // --- wind down and verdict ---
      hold_until_drained();
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== bit_crusher_interpolated.f =====
rtl/core/bci_pkg.sv
rtl/core/bci_if.sv
rtl/core/bci_front.sv
rtl/core/bci_queue.sv
rtl/core/bci_back.sv
rtl/core/bit_crusher_interpolated.sv
tb/sv/bci_checker.sv
tb/sv/testbench.sv
